/* rtl/blrs_pkg.sv */
// Shared types, constants and controller encodings of the bilinear RGB565 line scaler.
`default_nettype none
package blrs_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int DIM_W      = 9;
  localparam int RATIO_W    = 24;
  localparam int PROD_W     = RATIO_W + DIM_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int MAC_K_W    = 3;

  localparam logic [MAC_K_W-1:0] MAC_LAST = MAC_K_W'(4);

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_PULL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_RATIO   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALED_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCALED_HEIGHT = 3'd6;

  typedef struct packed {
    logic       cmd;
    logic [7:0] row_index;
    logic [15:0] in_pixel;
    logic       row_end;
  } item_t;

  typedef struct packed {
    logic        out_valid;
    logic [7:0]  out_col;
    logic [7:0]  out_row;
    logic [15:0] out_pixel;
    logic        image_done;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SEL,
    ST_PUSH,
    ST_CHK,
    ST_MAC,
    ST_FIN,
    ST_OUT
  } st_e;

  typedef struct packed {
    logic               load;
    logic               mul;
    logic               sel;
    logic               push;
    logic               clr;
    logic               drop_arm;
    logic               mac;
    logic [MAC_K_W-1:0] mac_k;
    logic               fin;
    logic               out_ld;
  } cmd_t;

  typedef struct packed {
    logic is_pull;
    logic run_ok;
    logic found;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

/* rtl/blrs_dp.sv */
// Datapath: configuration, line store, row/column selection, weights and blend.
`default_nettype none
module blrs_dp #(
  parameter int MAX_WIDTH  = blrs_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = blrs_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = blrs_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic [blrs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [blrs_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  blrs_pkg::item_t                      item_i,
  input  blrs_pkg::cmd_t                       cmd_i,
  output blrs_pkg::stat_t                      stat_o,
  input  logic                                 res_stall_i,
  output logic                                 res_valid_o,
  output blrs_pkg::res_t                       res_o
);
  import blrs_pkg::*;

  localparam int FCW = $clog2(MAX_WIDTH);
  localparam int AW  = $clog2(2 * MAX_WIDTH);
  localparam int WW  = FRAC_BITS + 1;
  localparam int WPW = 2 * FRAC_BITS + 2;
  localparam int PRW = WPW + 6;
  localparam int ACW = PRW - FRAC_BITS + 2;
  localparam logic [WW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef struct packed {
    logic [DIM_W-1:0] lo;
    logic [DIM_W-1:0] hi;
    logic [WW-1:0]    w;
  } pick_t;

  function automatic pick_t pick(input logic [PROD_W-1:0] p, input logic [DIM_W-1:0] size,
                                 input int maxv);
    pick_t            r;
    logic [DIM_W-1:0] s;
    logic [DIM_W-1:0] top;
    logic [PROD_W-1:0] l;
    logic [PROD_W-1:0] h;
    s = (size == '0) ? DIM_W'(1) : size;
    if (32'(s) > maxv) begin
      top = DIM_W'(maxv - 1);
    end else begin
      top = s - DIM_W'(1);
    end
    l = p >> FRAC_BITS;
    h = l + PROD_W'(p[FRAC_BITS-1:0] != '0);
    r.lo = (l > PROD_W'(top)) ? top : l[DIM_W-1:0];
    r.hi = (h > PROD_W'(top)) ? top : h[DIM_W-1:0];
    r.w  = (l > PROD_W'(top)) ? ONE : {1'b0, p[FRAC_BITS-1:0]};
    return r;
  endfunction

  // configuration
  logic [DIM_W-1:0]   in_w_q, in_h_q, fr_w_q, fr_h_q, sc_w_q, sc_h_q;
  logic [RATIO_W-1:0] ratio_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_w_q  <= DIM_W'(256);
      in_h_q  <= DIM_W'(256);
      fr_w_q  <= DIM_W'(240);
      fr_h_q  <= DIM_W'(240);
      ratio_q <= RATIO_W'(65536);
      sc_w_q  <= DIM_W'(240);
      sc_h_q  <= DIM_W'(240);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_IN_WIDTH:      in_w_q  <= cfg_data_i[DIM_W-1:0];
        REG_IN_HEIGHT:     in_h_q  <= cfg_data_i[DIM_W-1:0];
        REG_FRAME_WIDTH:   fr_w_q  <= cfg_data_i[DIM_W-1:0];
        REG_FRAME_HEIGHT:  fr_h_q  <= cfg_data_i[DIM_W-1:0];
        REG_SCALE_RATIO:   ratio_q <= cfg_data_i[RATIO_W-1:0];
        REG_SCALED_WIDTH:  sc_w_q  <= cfg_data_i[DIM_W-1:0];
        REG_SCALED_HEIGHT: sc_h_q  <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  logic [7:0]       tag_q [2];
  logic [7:0]       tag_d [2];
  logic             slot_q, slot_d, kept_q, kept_d, armed_q, armed_d;
  logic [FCW-1:0]   fill_q, fill_d;
  logic [DIM_W-1:0] row_q, row_d, col_q, col_d;
  logic             out_vld_q, out_vld_d;

  // payload
  item_t             item_q;
  logic [PROD_W-1:0] py_q, px_q;
  pick_t             py_s, px_s;
  logic [DIM_W-1:0]  ylo_q, yhi_q, xlo_q, xhi_q;
  logic [WW-1:0]     wy_q, wx_q;
  logic [15:0]       mem [2*MAX_WIDTH];
  logic [15:0]       rdata_q;
  logic [WPW-1:0]    wprod_q;
  logic [ACW-1:0]    acc_r_q, acc_g_q, acc_b_q, acc_r_d, acc_g_d, acc_b_d;
  res_t              pend_q, pend_d, out_q;

  logic             first, kept_n, slot_n, we, skip_lo, skip_hi;
  logic [AW-1:0]    waddr, raddr;
  logic [DIM_W-1:0] row_ext, tag0_ext, tag1_ext, tagd0_ext, tagd1_ext;
  logic             hit_l0, hit_l1, hit_h0, hit_h1, sl, sh;
  logic [WW-1:0]    wa, wb;
  logic [DIM_W-1:0] rd_x;
  logic             rd_slot;
  logic [PRW-1:0]   term_r, term_g, term_b;
  logic [DIM_W:0]   col_inc, hsw;

  assign py_s = pick(py_q, in_h_q, MAX_HEIGHT);
  assign px_s = pick(px_q, in_w_q, MAX_WIDTH);

  assign row_ext  = {1'b0, item_q.row_index};
  assign tag0_ext = {1'b0, tag_q[0]};
  assign tag1_ext = {1'b0, tag_q[1]};
  assign tagd0_ext = {1'b0, tag_d[0]};
  assign tagd1_ext = {1'b0, tag_d[1]};

  assign hit_l0 = tag0_ext == ylo_q;
  assign hit_l1 = tag1_ext == ylo_q;
  assign hit_h0 = tag0_ext == yhi_q;
  assign hit_h1 = tag1_ext == yhi_q;
  assign sl = hit_l1;
  assign sh = hit_h1;

  assign stat_o.is_pull  = item_q.cmd == CMD_PULL;
  assign stat_o.run_ok   = armed_q && (row_q < sc_h_q);
  assign stat_o.found    = (hit_l0 || hit_l1) && (hit_h0 || hit_h1);
  assign stat_o.out_free = !out_vld_q || !res_stall_i;

  // push: slot choice, store write, tags and arming
  always_comb begin
    tag_d[0] = tag_q[0];
    tag_d[1] = tag_q[1];
    slot_d   = slot_q;
    kept_d   = kept_q;
    fill_d   = fill_q;
    armed_d  = armed_q;
    first    = fill_q == '0;
    kept_n   = first ? (row_ext == ylo_q || row_ext == yhi_q) : kept_q;
    slot_n   = first ? ((ylo_q != tag0_ext && yhi_q != tag1_ext) ? 1'b0 : 1'b1) : slot_q;
    we       = 1'b0;
    waddr    = slot_n ? AW'(MAX_WIDTH) + AW'(fill_q) : AW'(fill_q);
    skip_lo  = 1'b0;
    skip_hi  = 1'b0;
    if (cmd_i.push) begin
      we     = kept_n;
      kept_d = kept_n;
      slot_d = slot_n;
      fill_d = (fill_q == FCW'(MAX_WIDTH - 1)) ? '0 : fill_q + FCW'(1);
      if (item_q.row_end) begin
        if (kept_n) begin
          tag_d[slot_n] = item_q.row_index;
        end
        fill_d  = '0;
        kept_d  = 1'b0;
        skip_lo = (tagd0_ext != ylo_q || tagd1_ext != ylo_q) && row_ext != ylo_q;
        skip_hi = (tagd0_ext != yhi_q || tagd1_ext != yhi_q) && row_ext != yhi_q;
        armed_d = !(skip_lo && skip_hi);
      end
    end
    if (cmd_i.drop_arm) begin
      armed_d = 1'b0;
    end
  end

  // corner fetch and weight product
  assign rd_slot = cmd_i.mac_k[1] ? sh : sl;
  assign rd_x    = cmd_i.mac_k[0] ? xhi_q : xlo_q;
  assign raddr   = rd_slot ? AW'(MAX_WIDTH) + AW'(rd_x) : AW'(rd_x);
  assign wa      = cmd_i.mac_k[0] ? wx_q : ONE - wx_q;
  assign wb      = cmd_i.mac_k[1] ? wy_q : ONE - wy_q;

  assign term_r = (PRW'(rdata_q[15:11]) * PRW'(wprod_q)) >> FRAC_BITS;
  assign term_g = (PRW'(rdata_q[10:5])  * PRW'(wprod_q)) >> FRAC_BITS;
  assign term_b = (PRW'(rdata_q[4:0])   * PRW'(wprod_q)) >> FRAC_BITS;

  always_comb begin
    acc_r_d = acc_r_q + ACW'(term_r);
    acc_g_d = acc_g_q + ACW'(term_g);
    acc_b_d = acc_b_q + ACW'(term_b);
    if (cmd_i.mac_k == '0) begin
      acc_r_d = '0;
      acc_g_d = '0;
      acc_b_d = '0;
    end
  end

  // position, advance and result
  assign col_inc = {1'b0, col_q} + (DIM_W+1)'(1);
  assign hsw     = {1'b0, sc_w_q} + (DIM_W+1)'(1);

  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    pend_d = pend_q;
    if (cmd_i.clr) begin
      pend_d = '0;
    end
    if (cmd_i.fin) begin
      pend_d.out_valid = 1'b1;
      pend_d.out_col   = col_q[7:0] + fr_w_q[8:1] - hsw[8:1];
      pend_d.out_row   = row_q[7:0] + fr_h_q[8:1] - 8'(({1'b0, sc_h_q} + 10'd1) >> 1);
      pend_d.out_pixel = {acc_r_q[FRAC_BITS+4:FRAC_BITS], acc_g_q[FRAC_BITS+5:FRAC_BITS],
                          acc_b_q[FRAC_BITS+4:FRAC_BITS]};
      pend_d.image_done = 1'b0;
      if (col_inc >= {1'b0, sc_w_q}) begin
        col_d = '0;
        row_d = row_q + DIM_W'(1);
      end else begin
        col_d = col_inc[DIM_W-1:0];
      end
    end
  end

  assign out_vld_d = cmd_i.out_ld ? 1'b1 : (out_vld_q && res_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q[0]  <= '0;
      tag_q[1]  <= '0;
      slot_q    <= 1'b0;
      kept_q    <= 1'b0;
      fill_q    <= '0;
      armed_q   <= 1'b0;
      row_q     <= '0;
      col_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      tag_q[0]  <= tag_d[0];
      tag_q[1]  <= tag_d[1];
      slot_q    <= slot_d;
      kept_q    <= kept_d;
      fill_q    <= fill_d;
      armed_q   <= armed_d;
      row_q     <= row_d;
      col_q     <= col_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    if (cmd_i.mul) begin
      py_q <= PROD_W'(ratio_q) * PROD_W'(row_q);
      px_q <= PROD_W'(ratio_q) * PROD_W'(col_q);
    end
    if (cmd_i.sel) begin
      ylo_q <= py_s.lo;
      yhi_q <= py_s.hi;
      wy_q  <= py_s.w;
      xlo_q <= px_s.lo;
      xhi_q <= px_s.hi;
      wx_q  <= px_s.w;
    end
    if (cmd_i.mac) begin
      wprod_q <= WPW'(wa) * WPW'(wb);
      acc_r_q <= acc_r_d;
      acc_g_q <= acc_g_d;
      acc_b_q <= acc_b_d;
    end
    pend_q <= pend_d;
    if (cmd_i.out_ld) begin
      out_q            <= pend_q;
      out_q.image_done <= row_q >= sc_h_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= item_q.in_pixel;
    end
    if (cmd_i.mac) begin
      rdata_q <= mem[raddr];
    end
  end

  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

endmodule
`default_nettype wire

/* rtl/blrs_ctrl.sv */
// Controller state machine sequencing push, pull and result hand-off.
`default_nettype none
module blrs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  output logic            item_stall_o,
  input  blrs_pkg::stat_t stat_i,
  output blrs_pkg::cmd_t  cmd_o
);
  import blrs_pkg::*;

  st_e                state_q, state_d;
  logic [MAC_K_W-1:0] k_q, k_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    cmd_o       = '0;
    cmd_o.mac_k = k_q;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_SEL;
      end
      ST_SEL: begin
        cmd_o.sel = 1'b1;
        state_d   = stat_i.is_pull ? ST_CHK : ST_PUSH;
      end
      ST_PUSH: begin
        cmd_o.push = 1'b1;
        cmd_o.clr  = 1'b1;
        state_d    = ST_OUT;
      end
      ST_CHK: begin
        if (!stat_i.run_ok) begin
          cmd_o.clr = 1'b1;
          state_d   = ST_OUT;
        end else if (!stat_i.found) begin
          cmd_o.clr      = 1'b1;
          cmd_o.drop_arm = 1'b1;
          state_d        = ST_OUT;
        end else begin
          k_d     = '0;
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        cmd_o.mac = 1'b1;
        if (k_q == MAC_LAST) begin
          state_d = ST_FIN;
        end else begin
          k_d = k_q + MAC_K_W'(1);
        end
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign item_stall_o = state_q != ST_IDLE;

`ifndef ASSERT_OFF
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && !stat_i.out_free) |=> state_q == ST_OUT)
    else $error("result hand-off left while output busy");
  a_mac_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC && k_q == MAC_LAST) |=> state_q == ST_FIN)
    else $error("blend did not finish after last corner");
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_i && !item_stall_o) |=> state_q == ST_MUL)
    else $error("accepted item not started");
  a_mac_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MAC |-> k_q <= MAC_LAST)
    else $error("corner counter out of range");
`endif

endmodule
`default_nettype wire

/* rtl/bilinear_rgb565_line_scaler.sv */
// Top level of the bilinear RGB565 line scaler.
`default_nettype none
// One item at a time. A push goes through multiply, select, store write and
// result hand-off before the next accept; a pull that delivers a pixel also
// makes four corner reads through the single line store read port and the
// shared weight multiplier; a pull that is refused skips the corner reads.
// A result waiting on a stalled output is held until it is taken. Config
// writes are always ready and take effect at once; write them only while idle.
module bilinear_rgb565_line_scaler #(
  parameter int MAX_WIDTH  = blrs_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = blrs_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = blrs_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [blrs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [blrs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            item_valid_i,
  output logic                            item_stall_o,
  input  blrs_pkg::item_t                 item_i,
  output logic                            res_valid_o,
  input  logic                            res_stall_i,
  output blrs_pkg::res_t                  res_o
);
  import blrs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  blrs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid_i),
    .item_stall_o (item_stall_o),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  blrs_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_stall_i (res_stall_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule
`default_nettype wire
